// ===== src/mrls_pkg.sv =====
// ----------------------------------------------------------------------------
// mrls_pkg
// Shared types, codes and the sequencer microprogram for the run-length store.
// ----------------------------------------------------------------------------
package mrls_pkg;

	localparam int MAX_RUNS_DEF  = 1024;
	localparam int POS_BITS_DEF  = 20;
	localparam int VAL_W         = 32;
	localparam int STEP_W        = 4;

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_LOOKUP = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_MONO = 2'd1,
		ST_OOR      = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// datapath actions, one per control word
	typedef enum logic [2:0] {
		A_NONE,
		A_LATCH,     // take a request from the input side
		A_APPEND,    // update the run table with the latched value
		A_LK_INIT,   // range check, set the search window
		A_RD_MID,    // read the midpoint entry
		A_NARROW,    // shrink the window from the read position
		A_RD_LO,     // read the found entry
		A_TAKE_VAL   // capture the found value
	} act_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_LOOKUP,
		C_MISS,
		C_DONE,
		C_OUT_FREE
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		act_t  act;
		logic  emit;   // load the output register when it is free
		cond_t cond;
		step_t jmp;
	} ucode_t;

	typedef struct packed {
		logic req;
		logic lookup;
		logic miss;
		logic done;
		logic out_free;
	} flags_t;

	localparam step_t S_IDLE    = 4'd0;
	localparam step_t S_DISP    = 4'd1;
	localparam step_t S_APPEND  = 4'd2;
	localparam step_t S_LK_INIT = 4'd3;
	localparam step_t S_LK_TEST = 4'd4;
	localparam step_t S_LK_STEP = 4'd5;
	localparam step_t S_LK_FIN  = 4'd6;
	localparam step_t S_LK_VAL  = 4'd7;
	localparam step_t S_EMIT    = 4'd8;
	localparam step_t S_EMIT_W  = 4'd9;

	// microprogram ROM: a false condition falls through to the next step
	function automatic ucode_t ucode(input step_t s);
		ucode_t u;
		u = '{act: A_NONE, emit: 1'b0, cond: C_ALWAYS, jmp: S_IDLE};
		case (s)
			S_IDLE:    u = '{act: A_LATCH,    emit: 1'b0, cond: C_NO_REQ,   jmp: S_IDLE};
			S_DISP:    u = '{act: A_NONE,     emit: 1'b0, cond: C_LOOKUP,   jmp: S_LK_INIT};
			S_APPEND:  u = '{act: A_APPEND,   emit: 1'b0, cond: C_ALWAYS,   jmp: S_EMIT};
			S_LK_INIT: u = '{act: A_LK_INIT,  emit: 1'b0, cond: C_MISS,     jmp: S_EMIT};
			S_LK_TEST: u = '{act: A_RD_MID,   emit: 1'b0, cond: C_DONE,     jmp: S_LK_FIN};
			S_LK_STEP: u = '{act: A_NARROW,   emit: 1'b0, cond: C_ALWAYS,   jmp: S_LK_TEST};
			S_LK_FIN:  u = '{act: A_RD_LO,    emit: 1'b0, cond: C_NEVER,    jmp: S_IDLE};
			S_LK_VAL:  u = '{act: A_TAKE_VAL, emit: 1'b0, cond: C_NEVER,    jmp: S_IDLE};
			S_EMIT:    u = '{act: A_NONE,     emit: 1'b1, cond: C_OUT_FREE, jmp: S_IDLE};
			S_EMIT_W:  u = '{act: A_NONE,     emit: 1'b0, cond: C_ALWAYS,   jmp: S_EMIT};
			default:   u = '{act: A_NONE,     emit: 1'b0, cond: C_ALWAYS,   jmp: S_IDLE};
		endcase
		return u;
	endfunction

endpackage

// ===== src/mrls_ram.sv =====
// ----------------------------------------------------------------------------
// mrls_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mrls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/mrls_seq.sv =====
// ----------------------------------------------------------------------------
// mrls_seq
// Step counter and microprogram ROM; issues one control word per cycle.
// ----------------------------------------------------------------------------
module mrls_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  mrls_pkg::flags_t flags,
	output mrls_pkg::ucode_t uc
);
	import mrls_pkg::*;

	step_t step_q;
	logic  take;

	assign uc = ucode(step_q);

	always_comb begin
		case (uc.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_REQ:   take = !flags.req;
			C_LOOKUP:   take = flags.lookup;
			C_MISS:     take = flags.miss;
			C_DONE:     take = flags.done;
			C_OUT_FREE: take = flags.out_free;
			default:    take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else if (take) begin
			step_q <= uc.jmp;
		end else begin
			step_q <= step_q + step_t'(1);
		end
	end

endmodule

// ===== src/mrls_dp.sv =====
// ----------------------------------------------------------------------------
// mrls_dp
// Datapath: run table RAM, cached tail run, search window, output register.
// ----------------------------------------------------------------------------
module mrls_dp #(
	parameter int MAX_RUNS      = mrls_pkg::MAX_RUNS_DEF,
	parameter int POSITION_BITS = mrls_pkg::POS_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mrls_pkg::ucode_t                uc,
	output mrls_pkg::flags_t                flags,
	input  logic                            in_valid,
	input  mrls_pkg::opcode_t               in_opcode,
	input  logic signed [mrls_pkg::VAL_W-1:0] in_value,
	input  logic [POSITION_BITS-1:0]        in_position,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic signed [mrls_pkg::VAL_W-1:0] out_value,
	output mrls_pkg::status_t               out_status,
	output logic [POSITION_BITS:0]          out_length
);
	import mrls_pkg::*;

	localparam int IDX_W = $clog2(MAX_RUNS);
	localparam int CNT_W = $clog2(MAX_RUNS + 1);
	localparam int ENT_W = VAL_W + POSITION_BITS;

	// request latch
	opcode_t                   op_q;
	logic signed [VAL_W-1:0]   val_q;
	logic [POSITION_BITS-1:0]  pos_q;

	// tail run cache and run count
	logic [CNT_W-1:0]          cnt_q;
	logic signed [VAL_W-1:0]   last_val_q;
	logic [POSITION_BITS-1:0]  last_pos_q;

	// search window
	logic [IDX_W-1:0]          lo_q, hi_q, mid_q, mid;

	// result
	logic signed [VAL_W-1:0]   res_val_q;
	status_t                   res_st_q;
	logic                      out_valid_q;

	// ram
	logic                      we;
	logic [IDX_W-1:0]          waddr, raddr;
	logic [ENT_W-1:0]          wdata, rdata;
	logic signed [VAL_W-1:0]   rd_val;
	logic [POSITION_BITS-1:0]  rd_pos;

	logic                      empty, pos_full, at_cap, smaller, equal;
	logic [POSITION_BITS-1:0]  next_pos;
	logic [IDX_W-1:0]          top;
	logic                      accept, emit_go;

	assign empty    = (cnt_q == '0);
	assign pos_full = (last_pos_q == {POSITION_BITS{1'b1}});
	assign at_cap   = (cnt_q == CNT_W'(MAX_RUNS));
	assign smaller  = (val_q < last_val_q);
	assign equal    = (val_q == last_val_q);
	assign next_pos = last_pos_q + POSITION_BITS'(1);
	assign top      = IDX_W'(cnt_q - CNT_W'(1));
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_val   = rdata[ENT_W-1:POSITION_BITS];
	assign rd_pos   = rdata[POSITION_BITS-1:0];

	assign accept   = (uc.act == A_LATCH) && in_valid;
	assign emit_go  = uc.emit && flags.out_free;

	assign flags.req      = in_valid;
	assign flags.lookup   = (op_q == OP_LOOKUP);
	assign flags.miss     = empty || (pos_q > last_pos_q);
	assign flags.done     = (lo_q >= hi_q);
	assign flags.out_free = !out_valid_q || out_ready;

	// write port: first run, extend of the tail run, or a new run
	always_comb begin
		we    = 1'b0;
		waddr = top;
		wdata = {val_q, next_pos};
		if (uc.act == A_APPEND) begin
			if (empty) begin
				we    = 1'b1;
				waddr = '0;
				wdata = {val_q, {POSITION_BITS{1'b0}}};
			end else if (!smaller && !pos_full) begin
				if (equal) begin
					we    = 1'b1;
					waddr = top;
					wdata = {last_val_q, next_pos};
				end else if (!at_cap) begin
					we    = 1'b1;
					waddr = cnt_q[IDX_W-1:0];
					wdata = {val_q, next_pos};
				end
			end
		end
	end

	assign raddr = (uc.act == A_RD_LO) ? lo_q : mid;

	mrls_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_RUNS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (uc.act == A_APPEND) begin
				if (empty) begin
					cnt_q <= CNT_W'(1);
				end else if (!smaller && !pos_full && !equal && !at_cap) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_opcode;
			val_q <= in_value;
			pos_q <= in_position;
		end
		case (uc.act)
			A_APPEND: begin
				res_val_q <= '0;
				if (empty) begin
					last_val_q <= val_q;
					last_pos_q <= '0;
					res_st_q   <= ST_OK;
				end else if (smaller) begin
					res_st_q <= ST_NOT_MONO;
				end else if (pos_full) begin
					res_st_q <= ST_FULL;
				end else if (equal) begin
					last_pos_q <= next_pos;
					res_st_q   <= ST_OK;
				end else if (at_cap) begin
					res_st_q <= ST_FULL;
				end else begin
					last_val_q <= val_q;
					last_pos_q <= next_pos;
					res_st_q   <= ST_OK;
				end
			end
			A_LK_INIT: begin
				res_val_q <= '0;
				res_st_q  <= ST_OOR;
				lo_q      <= '0;
				hi_q      <= top;
			end
			A_RD_MID: begin
				mid_q <= mid;
			end
			A_NARROW: begin
				if (rd_pos < pos_q) begin
					lo_q <= mid_q + IDX_W'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			A_TAKE_VAL: begin
				res_val_q <= rd_val;
				res_st_q  <= ST_OK;
			end
			default: ;
		endcase
		if (emit_go) begin
			out_value  <= res_val_q;
			out_status <= res_st_q;
			out_length <= empty ? '0 : ({1'b0, last_pos_q} + (POSITION_BITS + 1)'(1));
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/monotone_run_length_store_unit.sv =====
// ----------------------------------------------------------------------------
// monotone_run_length_store_unit
// Run-length store for a non-decreasing sequence, with lookup by position.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* channel carries requests: s_tuser selects append of a value (0) or
//    look up of the element at a position (1). One request is taken at a
//    time; s_tready is high only while the sequencer sits in its idle step.
//  - m_* channel returns exactly one result per request: value, status and
//    the stored length after the request.
//  - Steps from accept to m_tvalid: an append goes through dispatch, append
//    and emit; a lookup through dispatch, range check, k search iterations,
//    a final read, value capture and emit, with k at most
//    ceil(log2(run count)); a miss (empty or past the end) goes from range
//    check to emit. Each search iteration reads the midpoint entry from the
//    registered read port of the run table, then compares and narrows.
//  - The sequencer is idle again the cycle m_tvalid rises; a new request is
//    taken only once the previous result is in the output register.
//  - The result sits in an output register; the next request is taken while
//    it waits. If m_tready stays low, the next result waits in its emit step
//    and no further request is taken until the output register frees.
//  - Reset clears the run count and output valid; run table contents are
//    never read before being written, so the RAM has no clear pass.
// ----------------------------------------------------------------------------
module monotone_run_length_store_unit #(
	parameter int MAX_RUNS      = mrls_pkg::MAX_RUNS_DEF,
	parameter int POSITION_BITS = mrls_pkg::POS_BITS_DEF,
	localparam int S_W = ((mrls_pkg::VAL_W + POSITION_BITS + 7) / 8) * 8,
	localparam int M_W = ((mrls_pkg::VAL_W + 2 + POSITION_BITS + 1 + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [S_W-1:0] s_tdata,  // value_in[31:0], position, zero pad
	input  logic           s_tuser,  // opcode
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [M_W-1:0] m_tdata   // value_out[31:0], status[1:0], length_out, zero pad
);
	import mrls_pkg::*;

	localparam int S_USED = VAL_W + POSITION_BITS;
	localparam int M_USED = VAL_W + 2 + POSITION_BITS + 1;

	ucode_t                   uc;
	flags_t                   flags;
	opcode_t                  in_opcode;
	logic signed [VAL_W-1:0]  in_value;
	logic [POSITION_BITS-1:0] in_position;
	logic signed [VAL_W-1:0]  out_value;
	status_t                  out_status;
	logic [POSITION_BITS:0]   out_length;

	// unpack request; pad bits above S_USED are ignored
	assign in_opcode   = opcode_t'(s_tuser);
	assign in_value    = s_tdata[VAL_W-1:0];
	assign in_position = s_tdata[S_USED-1:VAL_W];

	// ready comes straight from the control word of the idle step
	assign s_tready = (uc.act == A_LATCH);

	mrls_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.flags (flags),
		.uc    (uc)
	);

	mrls_dp #(
		.MAX_RUNS     (MAX_RUNS),
		.POSITION_BITS(POSITION_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.uc         (uc),
		.flags      (flags),
		.in_valid   (s_tvalid),
		.in_opcode  (in_opcode),
		.in_value   (in_value),
		.in_position(in_position),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_value  (out_value),
		.out_status (out_status),
		.out_length (out_length)
	);

	// pack result, zero fill to whole bytes
	always_comb begin
		m_tdata = '0;
		m_tdata[M_USED-1:0] = {out_length, out_status, out_value};
	end

endmodule

// ===== src/mrls_chk.sv =====
// ----------------------------------------------------------------------------
// mrls_chk
// Port-level checks for the run-length store, bound to the top level.
// ----------------------------------------------------------------------------
module mrls_chk #(
	parameter int POSITION_BITS = mrls_pkg::POS_BITS_DEF,
	parameter int M_W = 56
) (
	input logic           clk,
	input logic           arst_n,
	input logic           s_tvalid,
	input logic           s_tready,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic [M_W-1:0] m_tdata
);
	import mrls_pkg::*;

	localparam int VO = 0;
	localparam int SO = VAL_W;
	localparam int LO = VAL_W + 2;

	logic [VAL_W-1:0]         c_value;
	logic [1:0]               c_status;
	logic [POSITION_BITS:0]   c_length;

	assign c_value  = m_tdata[SO-1:VO];
	assign c_status = m_tdata[LO-1:SO];
	assign c_length = m_tdata[LO+POSITION_BITS:LO];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request in flight: no back-to-back accept
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// failed requests carry a zero value
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (c_status != ST_OK) |-> (c_value == '0))
		else $error("nonzero value on failed request");

	// a successful request always leaves a non-empty store
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (c_status == ST_OK) |-> (c_length != '0))
		else $error("ok result with empty store");

endmodule

bind monotone_run_length_store_unit mrls_chk #(
	.POSITION_BITS(POSITION_BITS),
	.M_W          (M_W)
) u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
